// ===== rtl/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths, sizes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int DATA_W             = 32;   // sample time and value width
   localparam int WIN_W              = 7;    // window register width
   localparam int MAX_WINDOW_DEFAULT = 64;   // default ring depth
   localparam int SLOT_MAX_W         = 10;   // slot field width, covers rings up to 1024
   localparam int QUEUE_DEPTH        = 2;    // front-to-back command queue depth

   // One classified sample: payload plus every ring address the back needs.
   typedef struct packed {
      logic [DATA_W-1:0]     sample_time;
      logic [DATA_W-1:0]     sample_value;
      logic                  is_last;
      logic [SLOT_MAX_W-1:0] wr_slot;
      logic [SLOT_MAX_W-1:0] old_slot;
      logic [SLOT_MAX_W-1:0] emit_slot;
      logic [SLOT_MAX_W-1:0] flush_slot;
      logic                  sub_en;
      logic                  emit_en;
      logic                  avg_en;
      logic [WIN_W-1:0]      flush_cnt;
      logic [WIN_W-1:0]      window;
   } cmd_type;

endpackage

// ===== rtl/cma_req_if.sv =====
// ----------------------------------------------------------------------------
// cma_req_if
// Sample channel: valid/ready handshake with one timestamped sample a word.
// ----------------------------------------------------------------------------
interface cma_req_if import cma_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample_time;
   logic [DATA_W-1:0] sample_value;
   logic              is_last;

   modport source (output valid, sample_time, sample_value, is_last, input ready);
   modport sink   (input valid, sample_time, sample_value, is_last, output ready);

endinterface

// ===== rtl/cma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cma_rsp_if
// Result channel: valid/ready handshake with one averaged sample a word.
// ----------------------------------------------------------------------------
interface cma_rsp_if import cma_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_time;
   logic [DATA_W-1:0] out_value;
   logic              out_last;

   modport source (output valid, out_time, out_value, out_last, input ready);
   modport sink   (input valid, out_time, out_value, out_last, output ready);

endinterface

// ===== rtl/centered_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// centered_moving_average_core
// Centered moving average over a timestamped sample stream, with raw
// pass-through of edge samples and a flush on the last sample.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      word
//   req_if    in         valid/ready    sample_time, sample_value, is_last
//   rsp_if    out        valid/ready    out_time, out_value, out_last
//   csr_*     in         write enable   window_length (7 bits)
//
// A sample that yields an averaged word passes through the ring write, the
// emit read and the one-bit-a-cycle restoring divider before its word is put
// in the result register; a raw word skips the divider, a sample with no word
// ends at the ring write, and each flushed edge word adds a ring read and a put.
// Reset is synchronous: window back to 1, series cleared, ring contents
// left as they are (an entry is never read before the series writes it).
// A two-entry command queue lets the front keep taking samples while the
// back waits on a stalled result register.
//
module centered_moving_average_core import cma_pkg::*; #(
   parameter int MaxWindow = MAX_WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   cma_req_if.sink          req_if,
   cma_rsp_if.source        rsp_if,
   input  logic             csr_write_enable,
   input  logic [WIN_W-1:0] csr_write_data
);

   // Configured window, and the clamped window actually used.
   logic [WIN_W-1:0] window_length_ff, window_length_in;
   logic [WIN_W-1:0] window_eff;

   // Front-to-queue and queue-to-back command streams.
   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    back_valid, back_ready;
   cmd_type back_cmd;

   assign window_length_in = csr_write_enable ? csr_write_data : window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WIN_W'(1);
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   // Zero acts as one; anything past the ring depth acts as the depth.
   always_comb begin
      if (window_length_ff == '0) begin
         window_eff = WIN_W'(1);
      end else if (int'(window_length_ff) > MaxWindow) begin
         window_eff = WIN_W'(MaxWindow);
      end else begin
         window_eff = window_length_ff;
      end
   end

   // Front: take samples, keep ring position and fill, classify.
   // A window write also ends the current series.
   cma_front #(
      .MaxWindow (MaxWindow)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_write_enable),
      .window    (window_eff),
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   // Hold classified commands while the back is busy.
   cma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   // Back: ring storage, running sum, divider and result register.
   cma_back #(
      .MaxWindow (MaxWindow)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_write_enable),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== rtl/cma_ram.sv =====
// ----------------------------------------------------------------------------
// cma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cma_ram #(
   parameter int Width = 32,
   parameter int Depth = 64,
   localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cma_front.sv =====
// ----------------------------------------------------------------------------
// cma_front
// Accept samples, track ring position and fill, and classify each sample
// into a command carrying every ring address the back will touch.
// ----------------------------------------------------------------------------
module cma_front import cma_pkg::*; #(
   parameter int MaxWindow = MAX_WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic [WIN_W-1:0] window,
   cma_req_if.sink          req_if,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cmd_type          cmd
);

   localparam int AW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
   localparam int CW = $clog2(MaxWindow + 1);
   localparam int EW = ((CW > WIN_W) ? CW : WIN_W) + 1;
   localparam logic [EW-1:0] DEPTH_E = EW'(MaxWindow);

   logic [AW-1:0] ws_ff,   ws_in;
   logic [CW-1:0] seen_ff, seen_in;

   logic [EW-1:0] w_e, after_e, ws_e, seen_e, seen_new_e;
   logic [EW-1:0] old_e, emit_e, wsn_e, cnt_e, first_e;
   logic          accept;

   assign accept    = req_if.valid && cmd_ready;
   assign req_if.ready = cmd_ready;
   assign cmd_valid = req_if.valid;

   always_comb begin
      w_e        = EW'(window);
      after_e    = w_e - EW'(1) - (w_e >> 1);
      ws_e       = EW'(ws_ff);
      seen_e     = EW'(seen_ff);
      seen_new_e = (seen_e < DEPTH_E) ? seen_e + EW'(1) : seen_e;
      old_e      = (ws_e >= w_e) ? ws_e - w_e : ws_e + DEPTH_E - w_e;
      emit_e     = (ws_e >= after_e) ? ws_e - after_e : ws_e + DEPTH_E - after_e;
      wsn_e      = (ws_e == DEPTH_E - EW'(1)) ? '0 : ws_e + EW'(1);
      cnt_e      = '0;
      if (req_if.is_last) begin
         cnt_e = (after_e < seen_new_e) ? after_e : seen_new_e;
      end
      first_e    = (wsn_e >= cnt_e) ? wsn_e - cnt_e : wsn_e + DEPTH_E - cnt_e;
   end

   always_comb begin
      cmd.sample_time  = req_if.sample_time;
      cmd.sample_value = req_if.sample_value;
      cmd.is_last      = req_if.is_last;
      cmd.wr_slot      = SLOT_MAX_W'(ws_ff);
      cmd.old_slot     = SLOT_MAX_W'(old_e[AW-1:0]);
      cmd.emit_slot    = SLOT_MAX_W'(emit_e[AW-1:0]);
      cmd.flush_slot   = SLOT_MAX_W'(first_e[AW-1:0]);
      cmd.sub_en       = (seen_e >= w_e);
      cmd.emit_en      = (seen_new_e > after_e);
      cmd.avg_en       = (seen_new_e >= w_e);
      cmd.flush_cnt    = cnt_e[WIN_W-1:0];
      cmd.window       = window;
   end

   // Advance ring position on each accepted sample; drop the series on last or on a clear.
   always_comb begin
      ws_in   = ws_ff;
      seen_in = seen_ff;
      if (clear) begin
         ws_in   = '0;
         seen_in = '0;
      end else if (accept) begin
         if (req_if.is_last) begin
            ws_in   = '0;
            seen_in = '0;
         end else begin
            ws_in   = wsn_e[AW-1:0];
            seen_in = seen_new_e[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= '0;
         seen_ff <= '0;
      end else begin
         ws_ff   <= ws_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ===== rtl/cma_queue.sv =====
// ----------------------------------------------------------------------------
// cma_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module cma_queue import cma_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   cmd_type       entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff,  count_in;
   logic          push, pop;

   assign push_ready = (count_ff != NW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/cma_back.sv =====
// ----------------------------------------------------------------------------
// cma_back
// Carry out commands: ring write, running sum, bit-serial mean, edge flush
// and the result output register.
// ----------------------------------------------------------------------------
module cma_back import cma_pkg::*; #(
   parameter int MaxWindow = MAX_WINDOW_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    clear,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   cma_rsp_if.source rsp_if
);

   localparam int AW     = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
   localparam int SUM_W  = DATA_W + $clog2(MaxWindow);
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int RAM_W  = 2 * DATA_W;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_SUB_DATA   = 4'd1;
   localparam logic [3:0] ST_WRITE      = 4'd2;
   localparam logic [3:0] ST_EMIT_RD    = 4'd3;
   localparam logic [3:0] ST_EMIT_DATA  = 4'd4;
   localparam logic [3:0] ST_DIV        = 4'd5;
   localparam logic [3:0] ST_FLUSH_RD   = 4'd6;
   localparam logic [3:0] ST_FLUSH_DATA = 4'd7;
   localparam logic [3:0] ST_PUT        = 4'd8;

   logic [3:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [WIN_W-1:0]  flush_left_ff, flush_left_in;
   logic [AW-1:0]     flush_slot_ff, flush_slot_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DATA_W-1:0] res_time_ff, res_time_in;
   logic [DATA_W-1:0] res_value_ff, res_value_in;
   logic              res_last_ff, res_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_time_ff, out_time_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     rd_addr;
   logic [RAM_W-1:0]  rd_data;
   logic [DATA_W-1:0] rd_time, rd_value;
   logic [WIN_W:0]    trial, divisor_e, diff;
   logic              ge;
   logic              out_free;

   cma_ram #(
      .Width (RAM_W),
      .Depth (MaxWindow)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_ff.wr_slot[AW-1:0]),
      .wr_data ({cmd_ff.sample_time, cmd_ff.sample_value}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_time  = rd_data[RAM_W-1:DATA_W];
   assign rd_value = rd_data[DATA_W-1:0];

   // One restoring division step: shift in the next dividend bit.
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign divisor_e = {1'b0, cmd_ff.window};
   assign ge        = (trial >= divisor_e);
   assign diff      = trial - divisor_e;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sum_in        = sum_ff;
      flush_left_in = flush_left_ff;
      flush_slot_in = flush_slot_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      res_time_in   = res_time_ff;
      res_value_in  = res_value_ff;
      res_last_in   = res_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cmd_ff.emit_slot[AW-1:0];
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_time_in   = out_time_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in        = cmd;
               flush_left_in = cmd.flush_cnt;
               flush_slot_in = cmd.flush_slot[AW-1:0];
               if (cmd.sub_en) begin
                  // Read the sample leaving the window before its slot is reused.
                  rd_en    = 1'b1;
                  rd_addr  = cmd.old_slot[AW-1:0];
                  state_in = ST_SUB_DATA;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_SUB_DATA: begin
            sum_in   = sum_ff - SUM_W'(rd_value);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en  = 1'b1;
            sum_in = sum_ff + SUM_W'(cmd_ff.sample_value);
            if (cmd_ff.emit_en) begin
               state_in = ST_EMIT_RD;
            end else if (flush_left_ff != '0) begin
               state_in = ST_FLUSH_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cmd_ff.emit_slot[AW-1:0];
            state_in = ST_EMIT_DATA;
         end
         ST_EMIT_DATA: begin
            res_time_in = rd_time;
            res_last_in = cmd_ff.is_last && (flush_left_ff == '0);
            if (cmd_ff.avg_en) begin
               quo_in   = sum_ff;
               rem_in   = '0;
               dcnt_in  = DCNT_W'(SUM_W);
               state_in = ST_DIV;
            end else begin
               res_value_in = rd_value;
               state_in     = ST_PUT;
            end
         end
         ST_DIV: begin
            if (dcnt_ff != '0) begin
               rem_in  = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
               quo_in  = {quo_ff[SUM_W-2:0], ge};
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end else begin
               res_value_in = quo_ff[DATA_W-1:0];
               state_in     = ST_PUT;
            end
         end
         ST_FLUSH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = flush_slot_ff;
            state_in = ST_FLUSH_DATA;
         end
         ST_FLUSH_DATA: begin
            res_time_in   = rd_time;
            res_value_in  = rd_value;
            res_last_in   = (flush_left_ff == WIN_W'(1));
            flush_left_in = flush_left_ff - WIN_W'(1);
            flush_slot_in = (flush_slot_ff == AW'(MaxWindow - 1)) ?
                            '0 : flush_slot_ff + AW'(1);
            state_in      = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_time_in  = res_time_ff;
               out_value_in = res_value_ff;
               out_last_in  = res_last_ff;
               if (flush_left_ff != '0) begin
                  state_in = ST_FLUSH_RD;
               end else begin
                  if (cmd_ff.is_last) begin
                     sum_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      flush_slot_ff <= flush_slot_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      res_time_ff  <= res_time_in;
      res_value_ff <= res_value_in;
      res_last_ff  <= res_last_in;
      out_time_ff  <= out_time_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         flush_left_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         flush_left_ff <= flush_left_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_time  = out_time_ff;
   assign rsp_if.out_value = out_value_ff;
   assign rsp_if.out_last  = out_last_ff;

endmodule
